/* sv/lfu_pkg.sv */
// ---------------------------------------------------------------------------
// LFU cache table package
// Shared constants, default parameter values and the probe result that the
// entry compare unit hands back to the sequencer.
// ---------------------------------------------------------------------------
`default_nettype none

package lfu_pkg;

   localparam int DEF_CAPACITY   = 16;
   localparam int DEF_KEY_BITS   = 32;
   localparam int DEF_VALUE_BITS = 32;
   localparam int DEF_COUNT_BITS = 16;

   // Capacity-in-use register.
   localparam int              CSR_BITS  = 5;
   localparam logic [CSR_BITS-1:0] CSR_RESET = 5'd16;

   // Operation codes carried in the request tuser.
   localparam logic KIND_GET = 1'b0;
   localparam logic KIND_PUT = 1'b1;

   // Outcome of comparing one stored entry against the lookup key and the
   // best replacement candidate found so far.
   typedef struct packed {
      logic is_match;
      logic is_free;
      logic beats_best;
   } probe_type;

endpackage

`default_nettype wire

/* sv/lfu_probe_unit.sv */
// ---------------------------------------------------------------------------
// LFU entry probe unit
// Compares one stored entry with the lookup key and with the current
// eviction candidate (lowest use count, oldest on a tie).
// ---------------------------------------------------------------------------
`default_nettype none

module lfu_probe_unit #(
   parameter int KEY_BITS   = lfu_pkg::DEF_KEY_BITS,
   parameter int COUNT_BITS = lfu_pkg::DEF_COUNT_BITS,
   parameter int RANK_BITS  = 4
) (
   input  wire logic                  entry_valid,
   input  wire logic [KEY_BITS-1:0]   entry_key,
   input  wire logic [COUNT_BITS-1:0] entry_count,
   input  wire logic [RANK_BITS-1:0]  entry_rank,
   input  wire logic [KEY_BITS-1:0]   look_key,
   input  wire logic                  best_seen,
   input  wire logic [COUNT_BITS-1:0] best_count,
   input  wire logic [RANK_BITS-1:0]  best_rank,
   output lfu_pkg::probe_type         probe
);
   import lfu_pkg::*;

   logic fewer_uses;
   logic older_tie;

   assign fewer_uses = entry_count < best_count;
   assign older_tie  = (entry_count == best_count) && (entry_rank > best_rank);

   always_comb begin
      probe.is_free    = !entry_valid;
      probe.is_match   = entry_valid && (entry_key == look_key);
      probe.beats_best = entry_valid && (!best_seen || fewer_uses || older_tie);
   end

endmodule

`default_nettype wire

/* sv/lfu_cache_table_unit.sv */
// ---------------------------------------------------------------------------
// LFU cache table unit
// Key-value store with least-frequently-used replacement, least-recently-used
// tie break, walked entry by entry by a small sequencer.
// ---------------------------------------------------------------------------
// Usage:
//   A request beat on req_* carries one operation: tuser is the kind (get or
//   put), tdata holds the key in the low bits and the value above it. One
//   response beat on rsp_* follows each request: tuser bit 0 is hit, bit 1 is
//   evicted; tdata holds read_value low and evicted_key above it.
//   The csr_* channel writes the capacity-in-use register; it is always ready
//   and should only be written while no request is in flight.
// Timing:
//   A get hit or a put at non-zero capacity runs the match/victim scan and
//   then the recency update before the response beat is offered; a get
//   miss or a put at zero capacity skips the second pass. The match/victim
//   scan reads one entry per cycle and the recency update is a second pass
//   over the memory. req_tready is high only while idle, in the cycle after
//   the response is loaded, so a new request is taken only once the previous
//   one has finished. A new request may be accepted while the previous
//   response still waits; if the receiver stalls, the finished result is
//   held until the response register frees up.
// Reset:
//   Synchronous reset clears all valid bits, the entry count and the
//   sequencer, and sets the capacity register to 16. Memory contents are not
//   cleared; an entry is only looked at once its valid bit is set.
// ---------------------------------------------------------------------------
`default_nettype none

module lfu_cache_table_unit #(
   parameter int CAPACITY   = lfu_pkg::DEF_CAPACITY,
   parameter int KEY_BITS   = lfu_pkg::DEF_KEY_BITS,
   parameter int VALUE_BITS = lfu_pkg::DEF_VALUE_BITS,
   parameter int COUNT_BITS = lfu_pkg::DEF_COUNT_BITS,
   localparam int DATA_BITS = ((KEY_BITS + VALUE_BITS + 7) / 8) * 8
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   // Request channel.
   input  wire logic                         req_tvalid,
   output logic                              req_tready,
   input  wire logic [DATA_BITS-1:0]         req_tdata,   // key, value, zero pad
   input  wire logic                         req_tuser,   // kind
   // Response channel.
   output logic                              rsp_tvalid,
   input  wire logic                         rsp_tready,
   output logic [DATA_BITS-1:0]              rsp_tdata,   // read_value, evicted_key, pad
   output logic [1:0]                        rsp_tuser,   // hit, evicted
   // Capacity register write channel.
   input  wire logic                         csr_valid,
   output logic                              csr_ready,
   input  wire logic [lfu_pkg::CSR_BITS-1:0] csr_data
);
   import lfu_pkg::*;

   localparam int RANK_BITS = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int IDX_BITS  = RANK_BITS;
   localparam int CNT_BITS  = $clog2(CAPACITY + 1);
   localparam int LIM_BITS  = (CNT_BITS > CSR_BITS) ? CNT_BITS : CSR_BITS;

   typedef struct packed {
      logic [KEY_BITS-1:0]   key;
      logic [VALUE_BITS-1:0] value;
      logic [COUNT_BITS-1:0] count;
      logic [RANK_BITS-1:0]  rank;
   } entry_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DECIDE,
      ST_UPDATE,
      ST_FINISH
   } state_type;

   // Entry memory: one read and one write per cycle, read data registered.
   entry_type               mem [CAPACITY];
   entry_type               rd_ent_ff;
   logic [IDX_BITS-1:0]     rd_idx;
   logic                    wr_en;
   entry_type               wr_ent;

   state_type               state_ff;
   logic [CNT_BITS-1:0]     cnt_ff;
   logic                    proc_ff;
   logic [IDX_BITS-1:0]     proc_idx_ff;
   logic                    last_addr;

   logic                    kind_ff;
   logic [KEY_BITS-1:0]     key_ff;
   logic [VALUE_BITS-1:0]   val_ff;

   logic                    found_ff;
   logic [IDX_BITS-1:0]     match_idx_ff;
   entry_type               match_ent_ff;
   logic                    free_seen_ff;
   logic [IDX_BITS-1:0]     free_idx_ff;
   logic                    vic_seen_ff;
   logic [IDX_BITS-1:0]     vic_idx_ff;
   entry_type               vic_ent_ff;

   logic [IDX_BITS-1:0]     slot_ff;
   logic [RANK_BITS-1:0]    old_rank_ff;
   logic                    fresh_ff;
   entry_type               new_ent_ff;

   logic [CAPACITY-1:0]     valid_ff;
   logic [CNT_BITS-1:0]     used_ff;
   logic [CSR_BITS-1:0]     cap_ff;

   logic                    res_hit_ff;
   logic [VALUE_BITS-1:0]   res_rv_ff;
   logic                    res_ev_ff;
   logic [KEY_BITS-1:0]     res_evk_ff;

   logic                    out_valid_ff;
   logic                    out_hit_ff;
   logic [VALUE_BITS-1:0]   out_rv_ff;
   logic                    out_ev_ff;
   logic [KEY_BITS-1:0]     out_evk_ff;

   logic                    cur_valid;
   probe_type               probe;
   logic [COUNT_BITS-1:0]   bumped_count;
   logic [LIM_BITS-1:0]     cap_ext;
   logic [LIM_BITS-1:0]     limit;
   logic                    store_full;
   logic                    ages;

   // ------------------------------------------------------------------
   // Shared compare unit, fed with one entry per cycle during the scan.
   // ------------------------------------------------------------------
   assign cur_valid = valid_ff[proc_idx_ff];

   lfu_probe_unit #(
      .KEY_BITS   (KEY_BITS),
      .COUNT_BITS (COUNT_BITS),
      .RANK_BITS  (RANK_BITS)
   ) u_probe (
      .entry_valid (cur_valid),
      .entry_key   (rd_ent_ff.key),
      .entry_count (rd_ent_ff.count),
      .entry_rank  (rd_ent_ff.rank),
      .look_key    (key_ff),
      .best_seen   (vic_seen_ff),
      .best_count  (vic_ent_ff.count),
      .best_rank   (vic_ent_ff.rank),
      .probe       (probe)
   );

   // ------------------------------------------------------------------
   // Decision helpers.
   // ------------------------------------------------------------------
   assign bumped_count = (match_ent_ff.count == '1) ? match_ent_ff.count
                                                    : match_ent_ff.count + 1'b1;
   // Capacity values above the table size act as the table size.
   assign cap_ext    = LIM_BITS'(cap_ff);
   assign limit      = (cap_ext > LIM_BITS'(CAPACITY)) ? LIM_BITS'(CAPACITY) : cap_ext;
   assign store_full = LIM_BITS'(used_ff) >= limit;
   assign last_addr  = cnt_ff == CNT_BITS'(CAPACITY);

   // ------------------------------------------------------------------
   // Second pass: the touched slot gets its new contents at rank zero,
   // and every valid entry more recent than its old rank ages by one.
   // A freshly filled slot had no rank, so all other valid entries age.
   // ------------------------------------------------------------------
   assign ages = fresh_ff || (rd_ent_ff.rank < old_rank_ff);

   always_comb begin
      wr_en  = 1'b0;
      wr_ent = rd_ent_ff;
      if (state_ff == ST_UPDATE && proc_ff) begin
         if (proc_idx_ff == slot_ff) begin
            wr_en  = 1'b1;
            wr_ent = new_ent_ff;
         end else if (cur_valid && ages) begin
            wr_en       = 1'b1;
            wr_ent.rank = rd_ent_ff.rank + 1'b1;
         end
      end
   end

   assign rd_idx = cnt_ff[IDX_BITS-1:0];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[proc_idx_ff] <= wr_ent;
      end
      rd_ent_ff <= mem[rd_idx];
   end

   // ------------------------------------------------------------------
   // Configuration register.
   // ------------------------------------------------------------------
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff <= CSR_RESET;
      end else if (csr_valid && csr_ready) begin
         cap_ff <= csr_data;
      end
   end

   // ------------------------------------------------------------------
   // Sequencer.
   // ------------------------------------------------------------------
   assign req_tready = state_ff == ST_IDLE;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         proc_ff      <= 1'b0;
         valid_ff     <= '0;
         used_ff      <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         proc_ff     <= (state_ff == ST_SCAN || state_ff == ST_UPDATE) &&
                        (cnt_ff < CNT_BITS'(CAPACITY));
         proc_idx_ff <= rd_idx;

         if (rsp_tvalid && rsp_tready) begin
            out_valid_ff <= 1'b0;
         end

         case (state_ff)
            ST_IDLE: begin
               if (req_tvalid) begin
                  kind_ff      <= req_tuser;
                  key_ff       <= req_tdata[KEY_BITS-1:0];
                  val_ff       <= req_tdata[KEY_BITS+VALUE_BITS-1:KEY_BITS];
                  found_ff     <= 1'b0;
                  free_seen_ff <= 1'b0;
                  vic_seen_ff  <= 1'b0;
                  cnt_ff       <= '0;
                  state_ff     <= ST_SCAN;
               end
            end

            ST_SCAN: begin
               if (!last_addr) begin
                  cnt_ff <= cnt_ff + 1'b1;
               end
               if (proc_ff) begin
                  // The first matching entry wins, as does the first free one.
                  if (probe.is_match && !found_ff) begin
                     found_ff     <= 1'b1;
                     match_idx_ff <= proc_idx_ff;
                     match_ent_ff <= rd_ent_ff;
                  end
                  if (probe.is_free && !free_seen_ff) begin
                     free_seen_ff <= 1'b1;
                     free_idx_ff  <= proc_idx_ff;
                  end
                  if (probe.beats_best) begin
                     vic_seen_ff <= 1'b1;
                     vic_idx_ff  <= proc_idx_ff;
                     vic_ent_ff  <= rd_ent_ff;
                  end
               end
               if (last_addr) begin
                  state_ff <= ST_DECIDE;
               end
            end

            ST_DECIDE: begin
               res_hit_ff  <= found_ff;
               res_rv_ff   <= '0;
               res_ev_ff   <= 1'b0;
               res_evk_ff  <= '0;
               cnt_ff      <= '0;
               fresh_ff    <= 1'b0;
               state_ff    <= ST_FINISH;
               new_ent_ff.key   <= key_ff;
               new_ent_ff.value <= val_ff;
               new_ent_ff.count <= COUNT_BITS'(1);
               new_ent_ff.rank  <= '0;

               if (kind_ff == KIND_GET) begin
                  if (found_ff) begin
                     res_rv_ff        <= match_ent_ff.value;
                     new_ent_ff.value <= match_ent_ff.value;
                     new_ent_ff.count <= bumped_count;
                     slot_ff          <= match_idx_ff;
                     old_rank_ff      <= match_ent_ff.rank;
                     state_ff         <= ST_UPDATE;
                  end
               end else if (cap_ff != '0) begin
                  if (found_ff) begin
                     new_ent_ff.count <= bumped_count;
                     slot_ff          <= match_idx_ff;
                     old_rank_ff      <= match_ent_ff.rank;
                     state_ff         <= ST_UPDATE;
                  end else if (store_full) begin
                     // Evict the least used, oldest entry and reuse its slot.
                     res_ev_ff   <= 1'b1;
                     res_evk_ff  <= vic_ent_ff.key;
                     slot_ff     <= vic_idx_ff;
                     old_rank_ff <= vic_ent_ff.rank;
                     state_ff    <= ST_UPDATE;
                  end else begin
                     slot_ff               <= free_idx_ff;
                     old_rank_ff           <= '0;
                     fresh_ff              <= 1'b1;
                     valid_ff[free_idx_ff] <= 1'b1;
                     used_ff               <= used_ff + 1'b1;
                     state_ff              <= ST_UPDATE;
                  end
               end
            end

            ST_UPDATE: begin
               if (!last_addr) begin
                  cnt_ff <= cnt_ff + 1'b1;
               end else begin
                  state_ff <= ST_FINISH;
               end
            end

            ST_FINISH: begin
               if (!out_valid_ff || rsp_tready) begin
                  out_valid_ff <= 1'b1;
                  out_hit_ff   <= res_hit_ff;
                  out_rv_ff    <= res_rv_ff;
                  out_ev_ff    <= res_ev_ff;
                  out_evk_ff   <= res_evk_ff;
                  state_ff     <= ST_IDLE;
               end
            end

            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tuser  = {out_ev_ff, out_hit_ff};
   assign rsp_tdata  = DATA_BITS'({out_evk_ff, out_rv_ff});

endmodule

`default_nettype wire
